>>> rtl/core/encoder_speed_position_unwrap_defines.svh
// Assertion macros for the encoder unwrap block.
// Included by the top level; define NO_ASSERTIONS to compile them away.
`ifndef ENCODER_SPEED_POSITION_UNWRAP_DEFINES_SVH
`define ENCODER_SPEED_POSITION_UNWRAP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every clock edge out of reset.
`define ESPU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every clock edge out of reset.
`define ESPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ESPU_ASSERT_IMP(lbl, ante, cons, msg)
`define ESPU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/espu_pkg.sv
// Shared types and constants of the encoder unwrap block.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package espu_pkg;

  // Field widths.
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int OVF_W   = 16;
  localparam int TOT_W   = 32;
  localparam int SPEED_W = 37;
  localparam int POS_W   = 48;
  localparam int IDX_W   = 3;

  // Multiplier operands: a signed operand and an unsigned 16-bit gain.
  localparam int OPND_W  = 34;
  localparam int PROD_W  = OPND_W + CFG_W + 1;

  // Overflow count limits.
  localparam logic signed [OVF_W-1:0] OVF_MAX = 16'sh7FFF;
  localparam logic signed [OVF_W-1:0] OVF_MIN = 16'sh8000;

  // Register reset values.
  localparam logic [CFG_W-1:0] RELOAD_RST    = 16'd20000;
  localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd19000;
  localparam logic [CFG_W-1:0] SPD_GAIN_RST  = 16'd6431;
  localparam logic [CFG_W-1:0] POS_GAIN_RST  = 16'd64;
  localparam logic [CFG_W-1:0] POS_OFS_RST   = 16'd10000;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_RELOAD    = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_SPD_GAIN  = 3'd2,
    REG_POS_GAIN  = 3'd3,
    REG_POS_OFS   = 3'd4
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXT_MUL,
    ST_TOTAL,
    ST_WRAP,
    ST_DIFF,
    ST_SPD_MUL,
    ST_SPD_SAT,
    ST_PUSH,
    ST_POS_OP,
    ST_POS_MUL,
    ST_POS_SAT,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/espu_channels.sv
// Valid/ready channel interfaces for encoder samples and results.
// Depends on espu_pkg for the field widths.
`default_nettype none

interface espu_sample_if;
  logic                          valid;
  logic                          ready;
  logic [espu_pkg::CNT_W-1:0]    counter_value;
  logic                          counting_down;

  modport source (output valid, output counter_value, output counting_down, input ready);
  modport sink (input valid, input counter_value, input counting_down, output ready);
endinterface

interface espu_result_if;
  logic                               valid;
  logic                               ready;
  logic                               direction;
  logic signed [espu_pkg::SPEED_W-1:0] filtered_speed;
  logic signed [espu_pkg::POS_W-1:0]   position;

  modport source (output valid, output direction, output filtered_speed, output position,
                  input ready);
  modport sink (input valid, input direction, input filtered_speed, input position,
                output ready);
endinterface

`default_nettype wire

>>> rtl/core/encoder_speed_position_unwrap.sv
// Encoder counter unwrap with window-averaged speed and scaled position.
// Depends on espu_pkg, the channel interfaces and the assertion macro header.
`default_nettype none
`include "encoder_speed_position_unwrap_defines.svh"

// One sample transaction yields one result transaction. Each sample passes a
// small sequencer that reuses one 34x17-bit multiplier three times (overflow
// count times reload, count difference times speed gain, offset count times
// position gain) and then a divider that forms the window mean four quotient
// bits per cycle. No new sample is accepted until the current one has reached
// the output register. The finished result sits in an output register, so the
// next sample is taken while it waits.
// Configuration writes must only be issued while no sample is in flight.
module encoder_speed_position_unwrap #(
  parameter int WINDOW_DEPTH = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  espu_sample_if.sink                       sample,
  espu_result_if.source                     result,
  input  wire logic                         cfg_we,
  input  wire logic [espu_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [espu_pkg::CFG_W-1:0]   cfg_data
);

  localparam int SUM_W    = espu_pkg::SPEED_W + $clog2(WINDOW_DEPTH);
  localparam int DIV_STEP = 4;
  localparam int DIV_CYC  = (SUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W    = DIV_CYC * DIV_STEP;
  localparam int DCNT_W   = $clog2(DIV_CYC);
  localparam int REM_W    = $clog2(WINDOW_DEPTH);

  localparam logic [REM_W:0]    DIVISOR  = (REM_W + 1)'(WINDOW_DEPTH);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_CYC - 1);

  // Configuration registers.
  logic [espu_pkg::CFG_W-1:0] reload_value;
  logic [espu_pkg::CFG_W-1:0] wrap_threshold;
  logic [espu_pkg::CFG_W-1:0] speed_gain;
  logic [espu_pkg::CFG_W-1:0] position_gain;
  logic [espu_pkg::CFG_W-1:0] position_offset;

  // Sequencer and datapath state.
  espu_pkg::state_t state, state_next;
  logic sample_ready;

  logic [espu_pkg::CNT_W-1:0]           cnt;
  logic                                 dir;
  logic signed [espu_pkg::OVF_W-1:0]    overflow_count;
  logic signed [espu_pkg::TOT_W-1:0]    total;
  logic signed [espu_pkg::TOT_W-1:0]    last_total;
  logic signed [espu_pkg::OPND_W-1:0]   opnd;
  logic signed [espu_pkg::PROD_W-1:0]   prod;
  logic [espu_pkg::CFG_W-1:0]           mul_gain;
  logic signed [espu_pkg::SPEED_W-1:0]  spd;
  logic signed [espu_pkg::SPEED_W-1:0]  hist [WINDOW_DEPTH];
  logic signed [SUM_W-1:0]              sum;
  logic signed [espu_pkg::POS_W-1:0]    pos;

  // Divider state.
  logic [DIV_W-1:0]  div_q;
  logic [REM_W-1:0]  div_rem;
  logic              div_neg;
  logic [DCNT_W-1:0] div_count;
  logic [DIV_W-1:0]  div_q_next;
  logic [REM_W-1:0]  div_rem_next;

  // Output register.
  logic                                res_valid;
  logic                                res_direction;
  logic signed [espu_pkg::SPEED_W-1:0] res_speed;
  logic signed [espu_pkg::POS_W-1:0]   res_position;

  // Wrap detection terms.
  logic signed [espu_pkg::TOT_W:0] drop;
  logic signed [espu_pkg::TOT_W:0] rise;
  logic signed [espu_pkg::TOT_W:0] thr_ext;

  logic sample_fire;
  logic res_load;

  assign sample_fire = sample.valid && sample_ready;
  assign res_load    = (state == espu_pkg::ST_DONE) && (!res_valid || result.ready);

  assign sample.ready          = sample_ready;
  assign result.valid          = res_valid;
  assign result.direction      = res_direction;
  assign result.filtered_speed = res_speed;
  assign result.position       = res_position;

  // Configuration writes; indexes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value    <= espu_pkg::RELOAD_RST;
      wrap_threshold  <= espu_pkg::THRESHOLD_RST;
      speed_gain      <= espu_pkg::SPD_GAIN_RST;
      position_gain   <= espu_pkg::POS_GAIN_RST;
      position_offset <= espu_pkg::POS_OFS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        espu_pkg::REG_RELOAD:    reload_value    <= cfg_data;
        espu_pkg::REG_THRESHOLD: wrap_threshold  <= cfg_data;
        espu_pkg::REG_SPD_GAIN:  speed_gain      <= cfg_data;
        espu_pkg::REG_POS_GAIN:  position_gain   <= cfg_data;
        espu_pkg::REG_POS_OFS:   position_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      espu_pkg::ST_IDLE:    if (sample.valid) state_next = espu_pkg::ST_EXT_MUL;
      espu_pkg::ST_EXT_MUL: state_next = espu_pkg::ST_TOTAL;
      espu_pkg::ST_TOTAL:   state_next = espu_pkg::ST_WRAP;
      espu_pkg::ST_WRAP:    state_next = espu_pkg::ST_DIFF;
      espu_pkg::ST_DIFF:    state_next = espu_pkg::ST_SPD_MUL;
      espu_pkg::ST_SPD_MUL: state_next = espu_pkg::ST_SPD_SAT;
      espu_pkg::ST_SPD_SAT: state_next = espu_pkg::ST_PUSH;
      espu_pkg::ST_PUSH:    state_next = espu_pkg::ST_POS_OP;
      espu_pkg::ST_POS_OP:  state_next = espu_pkg::ST_POS_MUL;
      espu_pkg::ST_POS_MUL: state_next = espu_pkg::ST_POS_SAT;
      espu_pkg::ST_POS_SAT: state_next = espu_pkg::ST_DIV;
      espu_pkg::ST_DIV:     if (div_count == DIV_LAST) state_next = espu_pkg::ST_DONE;
      espu_pkg::ST_DONE:    if (res_load) state_next = espu_pkg::ST_IDLE;
      default:              state_next = espu_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and multiplier gain select.
  always_comb begin
    sample_ready = 1'b0;
    mul_gain     = position_gain;
    case (state)
      espu_pkg::ST_IDLE:    sample_ready = 1'b1;
      espu_pkg::ST_EXT_MUL: mul_gain = reload_value;
      espu_pkg::ST_SPD_MUL: mul_gain = speed_gain;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= espu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Wrap checks: previous minus new count, and new minus previous count.
  assign drop    = {last_total[espu_pkg::TOT_W-1], last_total} - {total[espu_pkg::TOT_W-1], total};
  assign rise    = {total[espu_pkg::TOT_W-1], total} - {last_total[espu_pkg::TOT_W-1], last_total};
  assign thr_ext = {(espu_pkg::TOT_W - espu_pkg::CFG_W + 1)'(0), wrap_threshold};

  // Shared multiplier with a registered product.
  always_ff @(posedge clk) begin
    prod <= opnd * $signed({1'b0, mul_gain});
  end

  // Count unwrap and speed/position datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_count <= '0;
      last_total     <= '0;
      sum            <= '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else begin
      case (state)
        espu_pkg::ST_IDLE: begin
          if (sample_fire) begin
            cnt  <= sample.counter_value;
            dir  <= sample.counting_down;
            opnd <= espu_pkg::OPND_W'(overflow_count);
          end
        end
        espu_pkg::ST_TOTAL: begin
          total <= {(espu_pkg::TOT_W - espu_pkg::CNT_W)'(0), cnt} + prod[espu_pkg::TOT_W-1:0];
        end
        espu_pkg::ST_WRAP: begin
          // A large backward jump means the counter wrapped upward, and the
          // reverse for a large forward jump; the step is skipped at the limits.
          if (drop > thr_ext) begin
            if (overflow_count != espu_pkg::OVF_MAX) begin
              overflow_count <= overflow_count + 16'sd1;
              total <= total + {(espu_pkg::TOT_W - espu_pkg::CFG_W)'(0), reload_value};
            end
          end else if (rise > thr_ext) begin
            if (overflow_count != espu_pkg::OVF_MIN) begin
              overflow_count <= overflow_count - 16'sd1;
              total <= total - {(espu_pkg::TOT_W - espu_pkg::CFG_W)'(0), reload_value};
            end
          end
        end
        espu_pkg::ST_DIFF: begin
          opnd       <= espu_pkg::OPND_W'(total) - espu_pkg::OPND_W'(last_total);
          last_total <= total;
        end
        espu_pkg::ST_SPD_SAT: begin
          // Clamp the scaled difference to the speed field.
          if (prod[espu_pkg::PROD_W-1:espu_pkg::SPEED_W-1] == '0 ||
              prod[espu_pkg::PROD_W-1:espu_pkg::SPEED_W-1] == '1) begin
            spd <= prod[espu_pkg::SPEED_W-1:0];
          end else if (prod[espu_pkg::PROD_W-1]) begin
            spd <= {1'b1, (espu_pkg::SPEED_W - 1)'(0)};
          end else begin
            spd <= {1'b0, {(espu_pkg::SPEED_W - 1){1'b1}}};
          end
        end
        espu_pkg::ST_PUSH: begin
          // Running window sum: add the newest value, drop the oldest.
          sum <= sum + SUM_W'(spd) - SUM_W'(hist[WINDOW_DEPTH-1]);
          for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
            hist[i] <= hist[i-1];
          end
          hist[0] <= spd;
        end
        espu_pkg::ST_POS_OP: begin
          opnd <= espu_pkg::OPND_W'(total) -
                  {(espu_pkg::OPND_W - espu_pkg::CFG_W)'(0), position_offset};
        end
        espu_pkg::ST_POS_SAT: begin
          // Clamp the scaled position to the position field.
          if (prod[espu_pkg::PROD_W-1:espu_pkg::POS_W-1] == '0 ||
              prod[espu_pkg::PROD_W-1:espu_pkg::POS_W-1] == '1) begin
            pos <= prod[espu_pkg::POS_W-1:0];
          end else if (prod[espu_pkg::PROD_W-1]) begin
            pos <= {1'b1, (espu_pkg::POS_W - 1)'(0)};
          end else begin
            pos <= {1'b0, {(espu_pkg::POS_W - 1){1'b1}}};
          end
        end
        default: ;
      endcase
    end
  end

  // Four restoring-division steps per cycle on the window sum magnitude.
  always_comb begin
    logic [REM_W:0] trial;
    div_q_next   = div_q;
    div_rem_next = div_rem;
    for (int s = 0; s < DIV_STEP; s++) begin
      trial      = {div_rem_next, div_q_next[DIV_W-1]};
      div_q_next = {div_q_next[DIV_W-2:0], 1'b0};
      if (trial >= DIVISOR) begin
        trial         = trial - DIVISOR;
        div_q_next[0] = 1'b1;
      end
      div_rem_next = trial[REM_W-1:0];
    end
  end

  // Divider: loaded with the sign and magnitude of the sum, then iterated.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_count <= '0;
    end else begin
      case (state)
        espu_pkg::ST_POS_OP: begin
          div_neg   <= sum[SUM_W-1];
          div_q     <= DIV_W'(sum[SUM_W-1] ? -sum : sum);
          div_rem   <= '0;
          div_count <= '0;
        end
        espu_pkg::ST_DIV: begin
          div_q     <= div_q_next;
          div_rem   <= div_rem_next;
          div_count <= div_count + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output register: holds the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_direction <= dir;
      res_speed     <= div_neg ? -espu_pkg::SPEED_W'(div_q) : espu_pkg::SPEED_W'(div_q);
      res_position  <= pos;
    end
  end

  // The overflow count moves by at most one step per transaction.
  `ESPU_ASSERT_IMP(a_ovf_step, !$past(rst), (overflow_count == $past(overflow_count)) || (overflow_count == $past(overflow_count) + 16'sd1) || (overflow_count == $past(overflow_count) - 16'sd1), "overflow count jumped by more than one")
  // Once a sample is taken, no further sample is taken until it is finished.
  `ESPU_ASSERT_NEXT(a_busy_after_accept, sample.valid && sample.ready, !sample.ready, "sample taken while busy")
  // A new result appears only at the end of the sequence.
  `ESPU_ASSERT_IMP(a_result_from_done, !$past(rst) && $rose(result.valid), $past(state) == espu_pkg::ST_DONE, "result raised outside the final step")

endmodule

`default_nettype wire
